@@ hdl/i2cms_pkg.sv @@
// ----------------------------------------------------------------------------
// I2C master bit sequencer package
// Command codes, line phases and the item and state types of the sequencer.
// ----------------------------------------------------------------------------
package i2cms_pkg;

    // command codes carried in the operation field
    localparam logic [2:0] OP_TICK     = 3'd0;
    localparam logic [2:0] OP_START_WR = 3'd1;
    localparam logic [2:0] OP_START_RD = 3'd2;
    localparam logic [2:0] OP_WRITE    = 3'd3;
    localparam logic [2:0] OP_READ     = 3'd4;
    localparam logic [2:0] OP_STOP     = 3'd5;
    localparam logic [2:0] OP_PROBE    = 3'd6;

    localparam logic [2:0] BIT_MSB = 3'd7;

    // S: start, B: bit out, A: acknowledge, T: stop, R: bit in
    typedef enum logic [3:0] {
        PH_S0, PH_S1, PH_S2,
        PH_B0, PH_B1, PH_B2,
        PH_A0, PH_A1, PH_A2, PH_A3,
        PH_T0, PH_T1, PH_T2,
        PH_R0, PH_R1, PH_R2
    } t_phase;

    typedef struct packed {
        logic drv;
        logic sda;
        logic scl;
    } t_lines;

    localparam t_lines LINES_IDLE = '{drv: 1'b1, sda: 1'b1, scl: 1'b1};

    typedef struct packed {
        logic [2:0] operation;
        logic [6:0] target_address;
        logic [7:0] data_byte;
        logic       last_byte;
        logic       sda_in;
    } t_cmd_item;

    typedef struct packed {
        logic       scl;
        logic       sda_out;
        logic       sda_drive;
        logic       busy_res;
        logic [7:0] rx_byte;
        logic       rx_valid;
        logic       byte_done;
        logic       ack_error;
    } t_res_item;

    // sequencer state; shift[8] holds the NACK flag or the last-byte flag
    typedef struct packed {
        logic [2:0] kind;
        t_phase     phase;
        logic [2:0] bit_idx;
        logic [8:0] shift;
        t_lines     lines;
    } t_seq_state;

endpackage

@@ hdl/i2cms_if.sv @@
// ----------------------------------------------------------------------------
// I2C master bit sequencer channels
// Valid/ready channels for command items and result items.
// ----------------------------------------------------------------------------
interface i2cms_cmd_if
    import i2cms_pkg::*;
();
    logic      valid;
    logic      ready;
    t_cmd_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface i2cms_res_if
    import i2cms_pkg::*;
();
    logic      valid;
    logic      ready;
    t_res_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ hdl/i2c_master_bit_sequencer.sv @@
// ----------------------------------------------------------------------------
// I2C master bit sequencer
// Tick-driven I2C master that steps one bus line phase per command item.
// ----------------------------------------------------------------------------
// Usage:
//   i_cmd carries one command item per tick: an operation code (tick only,
//   start write, start read, write byte, read byte, stop, probe), the slave
//   address, the byte to send, the last-byte flag and the sampled SDA level.
//   Every accepted item yields exactly one result item on o_res: the SCL,
//   SDA and SDA-direction levels for that phase, the busy flag, and the
//   rx_valid, byte_done and ack_error pulses with the received byte.
//   A command is taken only while the sequencer is idle; otherwise the
//   operation code is ignored and the running sequence advances.
// Pipeline and throughput:
//   An item is held in the input register; then the next-phase logic
//   updates the sequencer state and loads the result register, which
//   offers the result on o_res. One item per cycle is taken when o_res
//   is ready; the state register is the only loop.
// Reset:
//   Both registers empty, sequencer idle, lines at SCL high, SDA high, driven.
// Stall:
//   While a result waits unread, one more item may enter the input register;
//   then i_cmd.ready drops until the result is taken.
// ----------------------------------------------------------------------------
module i2c_master_bit_sequencer
    import i2cms_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    i2cms_cmd_if.sink          i_cmd,
    i2cms_res_if.source        o_res
);

    logic       r_in_valid;
    t_cmd_item  r_in;
    t_seq_state r_state;
    t_seq_state n_state;
    logic       r_out_valid;
    t_res_item  r_out;
    t_res_item  n_out;
    logic       w_advance;

    // move the held item into the result register when there is room
    assign w_advance   = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_cmd.ready = !r_in_valid || w_advance;

    i2cms_step u_step (
        .i_state (r_state),
        .i_cmd   (r_in),
        .o_state (n_state),
        .o_res   (n_out)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_cmd.ready) begin
            r_in_valid <= i_cmd.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.valid && i_cmd.ready) begin
            r_in <= i_cmd.data;
        end
    end

    // sequencer state advances once per item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.kind    <= OP_TICK;
            r_state.phase   <= PH_S0;
            r_state.bit_idx <= '0;
            r_state.shift   <= '0;
            r_state.lines   <= LINES_IDLE;
        end else if (w_advance) begin
            r_state <= n_state;
        end
    end

    // result register: hold while the receiver stalls
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out <= n_out;
        end
    end

    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out;

endmodule

@@ hdl/i2cms_step.sv @@
// ----------------------------------------------------------------------------
// I2C master bit sequencer step
// Next state and result of one tick, from the held state and one command.
// ----------------------------------------------------------------------------
module i2cms_step
    import i2cms_pkg::*;
(
    input  t_seq_state i_state,
    input  t_cmd_item  i_cmd,
    output t_seq_state o_state,
    output t_res_item  o_res
);

    t_seq_state w_st;
    t_res_item  w_res;
    logic       w_bit;
    logic       w_start;

    function automatic t_lines f_lines(logic scl, logic sda, logic drv);
        t_lines v;
        v.scl = scl;
        v.sda = sda;
        v.drv = drv;
        return v;
    endfunction

    always_comb begin
        w_st    = i_state;
        w_res   = '0;
        w_bit   = 1'b0;
        w_start = (i_state.kind == OP_TICK) && (i_cmd.operation != OP_TICK)
                  && (i_cmd.operation <= OP_PROBE);

        // take a new command only while idle
        if (w_start) begin
            w_st.kind    = i_cmd.operation;
            w_st.bit_idx = BIT_MSB;
            case (i_cmd.operation)
                OP_START_WR, OP_START_RD, OP_PROBE: begin
                    w_st.phase = PH_S0;
                    w_st.shift = {1'b0, i_cmd.target_address,
                                  (i_cmd.operation == OP_START_RD)};
                end
                OP_WRITE: begin
                    w_st.phase = PH_B0;
                    w_st.shift = {1'b0, i_cmd.data_byte};
                end
                OP_READ: begin
                    w_st.phase = PH_R0;
                    w_st.shift = {i_cmd.last_byte, 8'd0};
                end
                default: begin
                    w_st.phase = PH_T0;
                    w_st.shift = '0;
                end
            endcase
        end

        if (w_st.kind != OP_TICK) begin
            // a read sends its ACK/NACK from the flag bit
            w_bit = (w_st.kind == OP_READ) ? w_st.shift[8] : w_st.shift[w_st.bit_idx];
            case (w_st.phase)
                PH_S0: begin
                    w_st.lines = f_lines(1'b1, 1'b1, 1'b1);
                    w_st.phase = PH_S1;
                end
                PH_S1: begin
                    w_st.lines = f_lines(1'b1, 1'b0, 1'b1);
                    w_st.phase = PH_S2;
                end
                PH_S2: begin
                    w_st.lines   = f_lines(1'b0, 1'b0, 1'b1);
                    w_st.phase   = PH_B0;
                    w_st.bit_idx = BIT_MSB;
                end
                PH_B0: begin
                    w_st.lines = f_lines(1'b0, w_bit, 1'b1);
                    w_st.phase = PH_B1;
                end
                PH_B1: begin
                    w_st.lines = f_lines(1'b1, w_bit, 1'b1);
                    w_st.phase = PH_B2;
                end
                PH_B2: begin
                    w_st.lines = f_lines(1'b0, w_bit, 1'b1);
                    if (w_st.kind == OP_READ) begin
                        w_res.rx_byte   = w_st.shift[7:0];
                        w_res.rx_valid  = 1'b1;
                        w_res.byte_done = 1'b1;
                        w_st.kind       = OP_TICK;
                        w_st.phase      = PH_S0;
                    end else if (w_st.bit_idx != 3'd0) begin
                        w_st.bit_idx = w_st.bit_idx - 3'd1;
                        w_st.phase   = PH_B0;
                    end else begin
                        w_st.phase = PH_A0;
                    end
                end
                PH_A0: begin
                    w_st.lines = f_lines(1'b0, 1'b1, 1'b1);
                    w_st.phase = PH_A1;
                end
                PH_A1: begin
                    w_st.lines = f_lines(1'b1, 1'b1, 1'b1);
                    w_st.phase = PH_A2;
                end
                PH_A2: begin
                    w_st.lines = f_lines(1'b1, 1'b1, 1'b0);
                    if (i_cmd.sda_in) begin
                        w_st.shift[8] = 1'b1;
                    end
                    w_st.phase = PH_A3;
                end
                PH_A3: begin
                    w_st.lines = f_lines(1'b0, 1'b1, 1'b1);
                    if (w_st.kind == OP_PROBE) begin
                        w_st.phase = PH_T0;
                    end else begin
                        // NACK aborts without a stop condition
                        w_res.ack_error = w_st.shift[8];
                        w_res.byte_done = ~w_st.shift[8];
                        w_st.kind       = OP_TICK;
                        w_st.phase      = PH_S0;
                    end
                end
                PH_T0: begin
                    w_st.lines = f_lines(1'b0, 1'b0, 1'b1);
                    w_st.phase = PH_T1;
                end
                PH_T1: begin
                    w_st.lines = f_lines(1'b1, 1'b0, 1'b1);
                    w_st.phase = PH_T2;
                end
                PH_T2: begin
                    w_st.lines      = f_lines(1'b1, 1'b1, 1'b1);
                    w_res.ack_error = (w_st.kind == OP_PROBE) && w_st.shift[8];
                    w_res.byte_done = !((w_st.kind == OP_PROBE) && w_st.shift[8]);
                    w_st.kind       = OP_TICK;
                    w_st.phase      = PH_S0;
                end
                PH_R0: begin
                    w_st.lines   = f_lines(1'b0, 1'b1, 1'b1);
                    w_st.phase   = PH_R1;
                    w_st.bit_idx = BIT_MSB;
                end
                PH_R1: begin
                    w_st.lines = f_lines(1'b1, 1'b1, 1'b0);
                    if (i_cmd.sda_in) begin
                        w_st.shift[w_st.bit_idx] = 1'b1;
                    end
                    w_st.phase = PH_R2;
                end
                default: begin
                    // low half of a read bit; after bit 0 send the acknowledge
                    w_st.lines = f_lines(1'b0, 1'b1, 1'b0);
                    if (w_st.bit_idx != 3'd0) begin
                        w_st.bit_idx = w_st.bit_idx - 3'd1;
                        w_st.phase   = PH_R1;
                    end else begin
                        w_st.phase = PH_B0;
                    end
                end
            endcase
        end

        w_res.scl       = w_st.lines.scl;
        w_res.sda_out   = w_st.lines.sda;
        w_res.sda_drive = w_st.lines.drv;
        w_res.busy_res  = (w_st.kind != OP_TICK);
    end

    assign o_state = w_st;
    assign o_res   = w_res;

endmodule

@@ dv/tb_i2c_master_bit_sequencer.sv @@
// ----------------------------------------------------------------------------
// I2C master bit sequencer testbench
// Sends command transactions with random pauses on both channels, predicts
// the line phase and pulses of every tick, and checks each result in order.
// ----------------------------------------------------------------------------
module tb_i2c_master_bit_sequencer
    import i2cms_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    // undefined operation code; the sequencer treats it like a plain tick
    localparam logic [2:0] OP_NONE = 3'd7;
    // kind value of an idle sequencer
    localparam logic [2:0] KIND_IDLE = OP_TICK;

    localparam int unsigned PAUSE_MAX    = 18;
    localparam int unsigned RANDOM_ITEMS = 1580;
    // a result passes the input and result registers after its command; leave a margin
    localparam int unsigned DRAIN_CYCLES = 8;

    localparam t_seq_state SEQ_RESET = '{
        kind: KIND_IDLE, phase: PH_S0, bit_idx: 3'd0, shift: 9'd0, lines: LINES_IDLE
    };

    logic i_clk = 1'b0;
    logic i_rst_n;

    i2cms_cmd_if cmd_ch ();
    i2cms_res_if res_ch ();

    i2c_master_bit_sequencer DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_ch.sink),
        .o_res   (res_ch.source)
    );

    always #6 i_clk = ~i_clk;

    t_cmd_item   pending_cmds[$];   // commands not yet offered to the block
    t_res_item   expected_res[$];   // predicted line phases, oldest first
    t_seq_state  bus_model;         // sequencer state, advanced on acceptance
    t_seq_state  gen_model;         // sequencer state, advanced while queuing

    bit          send_steady;
    bit          take_steady;
    int unsigned send_pause;
    int unsigned take_pause;

    int unsigned mismatches;
    int unsigned n_items;
    int unsigned n_results;
    int unsigned n_done;
    int unsigned n_nack;
    int unsigned n_rx;
    int unsigned started[8];

    // ------------------------------------------------------------------------
    // Line and pulse prediction
    // ------------------------------------------------------------------------
    function automatic t_lines lines_of(logic scl, logic sda, logic drv);
        return {drv, sda, scl};
    endfunction

    // Advance the sequencer by one tick and return the result of that tick.
    function automatic t_res_item advance_bus(inout t_seq_state st, input t_cmd_item c);
        t_res_item r;
        logic      b;
        logic      fin;
        logic      fail;
        r    = '0;
        fin  = 1'b0;
        fail = 1'b0;

        // take a new command only while idle; the first phase runs this tick
        if (st.kind == KIND_IDLE && c.operation >= OP_START_WR && c.operation <= OP_PROBE) begin
            st.kind    = c.operation;
            st.bit_idx = BIT_MSB;
            case (c.operation)
                OP_START_WR, OP_START_RD, OP_PROBE: begin
                    st.phase = PH_S0;
                    st.shift = {1'b0, c.target_address, c.operation == OP_START_RD};
                end
                OP_WRITE: begin
                    st.phase = PH_B0;
                    st.shift = {1'b0, c.data_byte};
                end
                OP_READ: begin
                    st.phase = PH_R0;
                    st.shift = {c.last_byte, 8'h00};
                end
                default: begin
                    st.phase = PH_T0;
                    st.shift = '0;
                end
            endcase
        end

        if (st.kind != KIND_IDLE) begin
            // a read answers with its last-byte flag; all else sends the shift bit
            b = (st.kind == OP_READ) ? st.shift[8] : st.shift[st.bit_idx];
            case (st.phase)
                PH_S0: begin
                    st.lines = lines_of(1'b1, 1'b1, 1'b1);
                    st.phase = PH_S1;
                end
                PH_S1: begin
                    st.lines = lines_of(1'b1, 1'b0, 1'b1);
                    st.phase = PH_S2;
                end
                PH_S2: begin
                    st.lines   = lines_of(1'b0, 1'b0, 1'b1);
                    st.phase   = PH_B0;
                    st.bit_idx = BIT_MSB;
                end
                PH_B0: begin
                    st.lines = lines_of(1'b0, b, 1'b1);
                    st.phase = PH_B1;
                end
                PH_B1: begin
                    st.lines = lines_of(1'b1, b, 1'b1);
                    st.phase = PH_B2;
                end
                PH_B2: begin
                    st.lines = lines_of(1'b0, b, 1'b1);
                    if (st.kind == OP_READ) begin
                        r.rx_byte  = st.shift[7:0];
                        r.rx_valid = 1'b1;
                        fin        = 1'b1;
                    end else if (st.bit_idx != 3'd0) begin
                        st.bit_idx = st.bit_idx - 3'd1;
                        st.phase   = PH_B0;
                    end else begin
                        st.phase = PH_A0;
                    end
                end
                PH_A0: begin
                    st.lines = lines_of(1'b0, 1'b1, 1'b1);
                    st.phase = PH_A1;
                end
                PH_A1: begin
                    st.lines = lines_of(1'b1, 1'b1, 1'b1);
                    st.phase = PH_A2;
                end
                PH_A2: begin
                    st.lines = lines_of(1'b1, 1'b1, 1'b0);
                    if (c.sda_in)
                        st.shift[8] = 1'b1;
                    st.phase = PH_A3;
                end
                PH_A3: begin
                    st.lines = lines_of(1'b0, 1'b1, 1'b1);
                    // a probe always closes with a stop, even after a NACK
                    if (st.kind == OP_PROBE) begin
                        st.phase = PH_T0;
                    end else begin
                        fin  = 1'b1;
                        fail = st.shift[8];
                    end
                end
                PH_T0: begin
                    st.lines = lines_of(1'b0, 1'b0, 1'b1);
                    st.phase = PH_T1;
                end
                PH_T1: begin
                    st.lines = lines_of(1'b1, 1'b0, 1'b1);
                    st.phase = PH_T2;
                end
                PH_T2: begin
                    st.lines = lines_of(1'b1, 1'b1, 1'b1);
                    fin      = 1'b1;
                    fail     = (st.kind == OP_PROBE) && st.shift[8];
                end
                PH_R0: begin
                    st.lines   = lines_of(1'b0, 1'b1, 1'b1);
                    st.phase   = PH_R1;
                    st.bit_idx = BIT_MSB;
                end
                PH_R1: begin
                    st.lines = lines_of(1'b1, 1'b1, 1'b0);
                    if (c.sda_in)
                        st.shift[st.bit_idx] = 1'b1;
                    st.phase = PH_R2;
                end
                PH_R2: begin
                    st.lines = lines_of(1'b0, 1'b1, 1'b0);
                    if (st.bit_idx != 3'd0) begin
                        st.bit_idx = st.bit_idx - 3'd1;
                        st.phase   = PH_R1;
                    end else begin
                        // eight bits in; answer ACK or NACK through the bit-out phases
                        st.phase = PH_B0;
                    end
                end
            endcase

            if (fin) begin
                r.ack_error = fail;
                r.byte_done = !fail;
                st.kind     = KIND_IDLE;
                st.phase    = PH_S0;
            end
        end

        r.scl       = st.lines.scl;
        r.sda_out   = st.lines.sda;
        r.sda_drive = st.lines.drv;
        r.busy_res  = (st.kind != KIND_IDLE);
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    // Pause length for one transaction; flip now and then into a run with no pauses.
    function automatic int unsigned pause_len(inout bit steady);
        if ($urandom_range(0, 47) == 0)
            steady = !steady;
        return steady ? 0 : $urandom_range(0, PAUSE_MAX);
    endfunction

    function automatic t_cmd_item random_item(logic [2:0] op);
        t_cmd_item c;
        c.operation      = op;
        c.target_address = 7'($urandom);
        c.data_byte      = 8'($urandom);
        c.last_byte      = 1'($urandom);
        c.sda_in         = 1'($urandom);
        return c;
    endfunction

    // operation code sent while busy: the block must ignore it
    function automatic logic [2:0] busy_op();
        return $urandom_range(0, 1) ? OP_TICK : 3'($urandom_range(0, 7));
    endfunction

    task automatic queue_item(t_cmd_item c);
        void'(advance_bus(gen_model, c));
        pending_cmds.push_back(c);
    endtask

    // Queue one command and the ticks that carry it to the end. For a read,
    // pattern is the byte the slave puts on SDA; nack answers the acknowledge.
    task automatic issue_cmd(logic [2:0] op, logic [6:0] addr, logic [7:0] pattern,
                             logic last, logic nack);
        t_cmd_item c;
        // let whatever a noise burst started run out first
        while (gen_model.kind != KIND_IDLE)
            queue_item(random_item(busy_op()));
        c                = random_item(op);
        c.target_address = addr;
        c.data_byte      = pattern;
        c.last_byte      = last;
        queue_item(c);
        while (gen_model.kind != KIND_IDLE) begin
            c = random_item(busy_op());
            if (gen_model.phase == PH_A2)
                c.sda_in = nack;
            else if (gen_model.phase == PH_R1)
                c.sda_in = pattern[gen_model.bit_idx];
            queue_item(c);
        end
    endtask

    function automatic logic nack_draw();
        return ($urandom_range(0, 4) == 0);
    endfunction

    // ------------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------------
    task automatic report_mismatch(string msg);
        mismatches++;
        if (mismatches <= 40)
            $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    task automatic check_field(string name, logic [7:0] got, logic [7:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d %s got %h expected %h",
                                      n_results, name, got, want));
    endtask

    task automatic check_result(t_res_item got, t_res_item want);
        check_field("scl", 8'(got.scl), 8'(want.scl));
        check_field("sda_out", 8'(got.sda_out), 8'(want.sda_out));
        check_field("sda_drive", 8'(got.sda_drive), 8'(want.sda_drive));
        check_field("busy_res", 8'(got.busy_res), 8'(want.busy_res));
        check_field("rx_byte", got.rx_byte, want.rx_byte);
        check_field("rx_valid", 8'(got.rx_valid), 8'(want.rx_valid));
        check_field("byte_done", 8'(got.byte_done), 8'(want.byte_done));
        check_field("ack_error", 8'(got.ack_error), 8'(want.ack_error));
    endtask

    // ------------------------------------------------------------------------
    // Command driver: offer queued commands, predict on every accepted transaction
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_res_item want;
        if (!i_rst_n) begin
            cmd_ch.valid <= 1'b0;
            send_pause   <= 0;
            bus_model = SEQ_RESET;
        end else begin
            if (cmd_ch.valid && cmd_ch.ready) begin
                if (bus_model.kind == KIND_IDLE)
                    started[cmd_ch.data.operation]++;
                want = advance_bus(bus_model, cmd_ch.data);
                expected_res.push_back(want);
                n_items++;
                n_done += 32'(want.byte_done);
                n_nack += 32'(want.ack_error);
                n_rx   += 32'(want.rx_valid);
            end
            // advance only when the slot is free or its transaction just went through
            if (!cmd_ch.valid || cmd_ch.ready) begin
                if (send_pause != 0) begin
                    cmd_ch.valid <= 1'b0;
                    send_pause   <= send_pause - 1;
                end else if (pending_cmds.size() != 0) begin
                    cmd_ch.valid <= 1'b1;
                    cmd_ch.data  <= pending_cmds.pop_front();
                    send_pause   <= pause_len(send_steady);
                end else begin
                    cmd_ch.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result monitor: take results with random stalls and compare in order
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        int unsigned w;
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
            take_pause   <= 0;
        end else if (res_ch.valid && res_ch.ready) begin
            if (expected_res.size() == 0)
                report_mismatch("result arrived with nothing expected");
            else
                check_result(res_ch.data, expected_res.pop_front());
            n_results++;
            // drop ready for the stall drawn for the next transaction
            w = pause_len(take_steady);
            take_pause   <= w;
            res_ch.ready <= (w == 0);
        end else if (take_pause != 0) begin
            take_pause   <= take_pause - 1;
            res_ch.ready <= (take_pause == 1);
        end else begin
            res_ch.ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus, reset and end of run
    // ------------------------------------------------------------------------
    initial begin
        int unsigned directed_items;
        int unsigned pick;
        int unsigned n;
        logic [6:0]  addr;

        i_rst_n      = 1'b0;
        cmd_ch.valid = 1'b0;
        cmd_ch.data  = '0;
        res_ch.ready = 1'b0;
        gen_model    = SEQ_RESET;

        // directed: idle codes with all-ones fields, every command, both
        // acknowledge answers, address and data extremes, last-byte NACK
        queue_item('{operation: OP_TICK, target_address: 7'h7f, data_byte: 8'hff,
                     last_byte: 1'b1, sda_in: 1'b1});
        queue_item('{operation: OP_NONE, target_address: 7'h7f, data_byte: 8'hff,
                     last_byte: 1'b1, sda_in: 1'b1});
        issue_cmd(OP_START_WR, 7'h00, 8'h00, 1'b0, 1'b0);
        issue_cmd(OP_WRITE, 7'h00, 8'hff, 1'b0, 1'b0);
        issue_cmd(OP_WRITE, 7'h7f, 8'h00, 1'b1, 1'b1);   // NACK on data aborts
        issue_cmd(OP_WRITE, 7'h2a, 8'ha5, 1'b0, 1'b0);
        issue_cmd(OP_STOP, 7'h00, 8'h00, 1'b0, 1'b0);
        issue_cmd(OP_START_RD, 7'h7f, 8'hff, 1'b1, 1'b0);
        issue_cmd(OP_READ, 7'h00, 8'hff, 1'b0, 1'b0);
        issue_cmd(OP_READ, 7'h7f, 8'h00, 1'b0, 1'b1);
        issue_cmd(OP_READ, 7'h55, 8'h5a, 1'b1, 1'b0);    // last byte, answered NACK
        issue_cmd(OP_STOP, 7'h7f, 8'hff, 1'b1, 1'b1);
        issue_cmd(OP_PROBE, 7'h55, 8'h00, 1'b0, 1'b0);
        issue_cmd(OP_PROBE, 7'h7f, 8'hff, 1'b1, 1'b1);   // NACK still sends stop
        issue_cmd(OP_START_WR, 7'h2a, 8'h3c, 1'b0, 1'b1); // NACK on the address
        directed_items = pending_cmds.size();

        // random: mostly complete bus transfers, some loose commands and noise
        while (pending_cmds.size() < directed_items + RANDOM_ITEMS) begin
            pick = $urandom_range(0, 19);
            addr = 7'($urandom);
            if (pick < 6) begin
                issue_cmd(OP_START_WR, addr, 8'($urandom), 1'($urandom), nack_draw());
                n = $urandom_range(1, 4);
                repeat (n)
                    issue_cmd(OP_WRITE, 7'($urandom), 8'($urandom), 1'($urandom), nack_draw());
                issue_cmd(OP_STOP, 7'($urandom), 8'($urandom), 1'($urandom), nack_draw());
            end else if (pick < 11) begin
                issue_cmd(OP_START_RD, addr, 8'($urandom), 1'($urandom), nack_draw());
                n = $urandom_range(1, 4);
                for (int k = 0; k < n; k++)
                    issue_cmd(OP_READ, 7'($urandom), 8'($urandom), k == n - 1, nack_draw());
                issue_cmd(OP_STOP, 7'($urandom), 8'($urandom), 1'($urandom), nack_draw());
            end else if (pick < 14) begin
                issue_cmd(OP_PROBE, addr, 8'($urandom), 1'($urandom), nack_draw());
            end else if (pick < 17) begin
                issue_cmd(3'($urandom_range(1, 6)), addr, 8'($urandom), 1'($urandom),
                          nack_draw());
            end else if (pick < 19) begin
                repeat ($urandom_range(1, 3))
                    queue_item(random_item($urandom_range(0, 1) ? OP_TICK : OP_NONE));
            end else begin
                // noise: anything at all, possibly leaving a command half done
                repeat ($urandom_range(1, 30))
                    queue_item(random_item(3'($urandom_range(0, 7))));
            end
        end

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // hold until every command went out and every result came back
        while (pending_cmds.size() != 0 || cmd_ch.valid)
            @(negedge i_clk);
        while (expected_res.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("Run covered %0d command transactions and %0d checked results;",
                 n_items, n_results);
        $display({"%0d start-wr, %0d start-rd, %0d write, %0d read, %0d stop, ",
                  "%0d probe; %0d done, %0d NACK, %0d rx"},
                 started[OP_START_WR], started[OP_START_RD], started[OP_WRITE],
                 started[OP_READ], started[OP_STOP], started[OP_PROBE],
                 n_done, n_nack, n_rx);
        if (mismatches == 0) begin
            $display("** i2c_master_bit_sequencer: PASSED **");
        end else begin
            $display("** i2c_master_bit_sequencer: FAILED **");
        end
        $finish;
    end

    // watchdog: a correct run takes far less than this
    initial begin
        #20ms;
        $display("Run timed out with %0d results still expected", expected_res.size());
        $display("** i2c_master_bit_sequencer: FAILED **");
        $finish;
    end

endmodule
